// ===== sv/wfe_pkg.sv =====
// ----------------------------------------------------------------------------
// wfe_pkg: shared types and constants of the water frame Euler angle unit
// Widths of the fixed-point datapath, the CORDIC arctangent table and the
// normalizing shift helper.
// ----------------------------------------------------------------------------
package wfe_pkg;

	localparam int COORD_W   = 24;
	localparam int N_COORDS  = 9;
	localparam int IN_W      = COORD_W * N_COORDS;
	localparam int DIFF_W    = COORD_W + 1;
	localparam int PROD_W    = 2 * DIFF_W;
	localparam int CROSS_W   = PROD_W + 1;
	localparam int CMAG_W    = PROD_W;
	localparam int PRE_LIMIT = 29;
	localparam int PRE_W     = PRE_LIMIT + 1;
	localparam int SHIFT_W   = 5;
	localparam int LEAD_W    = 56;
	localparam int ROOT_W    = 30;
	localparam int RAD_W     = 2 * ROOT_W;
	localparam int SQ_W      = 2 * PRE_LIMIT;
	localparam int GAM_W     = 56;
	localparam int CORDIC_IW = 31;
	localparam int CORDIC_STEPS = 24;
	localparam int ZACC_W    = 32;

	typedef logic [ZACC_W-1:0] zacc_t;

	typedef struct packed {
		logic                     degen;
		logic signed [PRE_W-1:0]  cx;
		logic signed [PRE_W-1:0]  cy;
		logic signed [PRE_W-1:0]  cz;
		logic signed [DIFF_W-1:0] ax;
		logic signed [DIFF_W-1:0] ay;
		logic signed [DIFF_W-1:0] az;
	} wfe_frame_t;

	// atan(2^-i), 2^31 = pi, rounded to nearest
	localparam zacc_t ATAN_TAB [CORDIC_STEPS] = '{
		32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
		32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
		32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
		32'd166886,    32'd83443,     32'd41722,     32'd20861,
		32'd10430,     32'd5215,      32'd2608,      32'd1304,
		32'd652,       32'd326,       32'd163,       32'd81
	};

	// smallest right shift that brings v below 2^PRE_LIMIT
	function automatic logic [SHIFT_W-1:0] fit_shift(input logic [LEAD_W-1:0] v);
		logic [SHIFT_W-1:0] s;
		s = '0;
		for (int i = PRE_LIMIT; i < LEAD_W; i++) begin
			if (v[i]) begin
				s = SHIFT_W'(i - PRE_LIMIT + 1);
			end
		end
		return s;
	endfunction

endpackage

// ===== sv/wfe_delay.sv =====
// ----------------------------------------------------------------------------
// wfe_delay: enabled shift line
// Holds side data of the pipeline for a fixed number of stages.
// ----------------------------------------------------------------------------
module wfe_delay #(
	parameter int W = 8,
	parameter int D = 1
) (
	input  logic         clk,
	input  logic         ce,
	input  logic [W-1:0] din,
	output logic [W-1:0] dout
);

	logic [W-1:0] dl_s [D];

	always_ff @(posedge clk) begin
		if (ce) begin
			dl_s[0] <= din;
			for (int k = 1; k < D; k++) begin
				dl_s[k] <= dl_s[k-1];
			end
		end
	end

	assign dout = dl_s[D-1];

endmodule

// ===== sv/wfe_front.sv =====
// ----------------------------------------------------------------------------
// wfe_front: bond vectors, cross product and common prescale
// Six stages: differences, products, cross sums, magnitudes, shift count,
// shifted signed components.
// ----------------------------------------------------------------------------
module wfe_front (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      ce,
	input  logic                      in_valid,
	input  logic [wfe_pkg::IN_W-1:0]  in_data,
	output logic                      out_valid,
	output wfe_pkg::wfe_frame_t       out_frame
);

	localparam int CW = wfe_pkg::COORD_W;
	localparam int DW = wfe_pkg::DIFF_W;
	localparam int PW = wfe_pkg::PROD_W;
	localparam int XW = wfe_pkg::CROSS_W;
	localparam int MW = wfe_pkg::CMAG_W;
	localparam int SW = wfe_pkg::PRE_W;
	localparam int LIM = wfe_pkg::PRE_LIMIT;

	logic signed [CW-1:0] crd [wfe_pkg::N_COORDS];
	logic signed [DW-1:0] a_s1 [3], b_s1 [3];
	logic signed [DW-1:0] a_s2 [3], a_s3 [3], a_s4 [3], a_s5 [3], a_s6 [3];
	logic signed [PW-1:0] pp_s2 [3], pn_s2 [3];
	logic signed [XW-1:0] c_s3 [3];
	logic [MW-1:0]        mag_s4 [3], mag_s5 [3];
	logic                 sgn_s4 [3], sgn_s5 [3];
	logic [wfe_pkg::SHIFT_W-1:0] shift_s5;
	logic                 degen_s5, degen_s6;
	logic signed [SW-1:0] c_s6 [3];
	logic                 vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6;

	always_comb begin
		for (int k = 0; k < wfe_pkg::N_COORDS; k++) begin
			crd[k] = in_data[k*CW +: CW];
		end
	end

	// bond vectors d1 = H1 - O, d2 = H2 - O
	always_ff @(posedge clk) begin
		if (ce) begin
			for (int k = 0; k < 3; k++) begin
				a_s1[k] <= DW'(crd[3+k]) - DW'(crd[k]);
				b_s1[k] <= DW'(crd[6+k]) - DW'(crd[k]);
			end
		end
	end

	for (genvar k = 0; k < 3; k++) begin : g_comp
		localparam int K1 = (k + 1) % 3;
		localparam int K2 = (k + 2) % 3;
		logic signed [XW-1:0] ng;
		logic [MW-1:0]        sh;
		logic signed [SW-1:0] val;

		assign ng  = -c_s3[k];
		assign sh  = mag_s5[k] >> shift_s5;
		assign val = {1'b0, sh[LIM-1:0]};

		always_ff @(posedge clk) begin
			if (ce) begin
				pp_s2[k]  <= a_s1[K1] * b_s1[K2];
				pn_s2[k]  <= a_s1[K2] * b_s1[K1];
				a_s2[k]   <= a_s1[k];
				c_s3[k]   <= XW'(pp_s2[k]) - XW'(pn_s2[k]);
				a_s3[k]   <= a_s2[k];
				mag_s4[k] <= c_s3[k][XW-1] ? ng[MW-1:0] : c_s3[k][MW-1:0];
				sgn_s4[k] <= c_s3[k][XW-1];
				a_s4[k]   <= a_s3[k];
				mag_s5[k] <= mag_s4[k];
				sgn_s5[k] <= sgn_s4[k];
				a_s5[k]   <= a_s4[k];
				c_s6[k]   <= sgn_s5[k] ? -val : val;
				a_s6[k]   <= a_s5[k];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ce) begin
			shift_s5 <= wfe_pkg::fit_shift(wfe_pkg::LEAD_W'(mag_s4[0] | mag_s4[1] | mag_s4[2]));
			degen_s5 <= ((mag_s4[0] | mag_s4[1] | mag_s4[2]) == '0);
			degen_s6 <= degen_s5;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
		end else if (ce) begin
			vld_s1 <= in_valid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
			vld_s6 <= vld_s5;
		end
	end

	assign out_valid       = vld_s6;
	assign out_frame.degen = degen_s6;
	assign out_frame.cx    = c_s6[0];
	assign out_frame.cy    = c_s6[1];
	assign out_frame.cz    = c_s6[2];
	assign out_frame.ax    = a_s6[0];
	assign out_frame.ay    = a_s6[1];
	assign out_frame.az    = a_s6[2];

endmodule

// ===== sv/wfe_isqrt.sv =====
// ----------------------------------------------------------------------------
// wfe_isqrt: pipelined integer square root
// One result bit per stage, floor(sqrt(n)).
// ----------------------------------------------------------------------------
module wfe_isqrt #(
	parameter int RW = 30
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            ce,
	input  logic            in_valid,
	input  logic [2*RW-1:0] radicand,
	output logic            out_valid,
	output logic [RW-1:0]   root
);

	localparam int NW = 2 * RW;

	logic [NW-1:0] n_s [RW];
	logic [NW-1:0] r_s [RW];
	logic          vld_s [RW];

	for (genvar k = 0; k < RW; k++) begin : g_stage
		localparam logic [NW-1:0] BIT = NW'(1) << (2 * (RW - 1 - k));
		logic [NW-1:0] nin, rin, trial;
		logic          vin;

		if (k == 0) begin : g_first
			assign nin = radicand;
			assign rin = '0;
			assign vin = in_valid;
		end else begin : g_next
			assign nin = n_s[k-1];
			assign rin = r_s[k-1];
			assign vin = vld_s[k-1];
		end

		assign trial = rin + BIT;

		always_ff @(posedge clk) begin
			if (ce) begin
				if (nin >= trial) begin
					n_s[k] <= nin - trial;
					r_s[k] <= (rin >> 1) + BIT;
				end else begin
					n_s[k] <= nin;
					r_s[k] <= rin >> 1;
				end
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k] <= 1'b0;
			end else if (ce) begin
				vld_s[k] <= vin;
			end
		end
	end

	assign root      = r_s[RW-1][RW-1:0];
	assign out_valid = vld_s[RW-1];

endmodule

// ===== sv/wfe_cordic.sv =====
// ----------------------------------------------------------------------------
// wfe_cordic: pipelined vectoring CORDIC atan2
// Quadrant fold, one micro-rotation per stage, rounding to AB-bit angle.
// ----------------------------------------------------------------------------
module wfe_cordic #(
	parameter int IW = 31,
	parameter int AB = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 ce,
	input  logic                 in_valid,
	input  logic signed [IW-1:0] y_in,
	input  logic signed [IW-1:0] x_in,
	output logic                 out_valid,
	output logic [AB-1:0]        angle
);

	localparam int CW = IW + 3;
	localparam int N  = wfe_pkg::CORDIC_STEPS;
	localparam int ZW = wfe_pkg::ZACC_W;
	localparam wfe_pkg::zacc_t RND = wfe_pkg::zacc_t'(1) << (ZW - 1 - AB);
	localparam wfe_pkg::zacc_t HALF_TURN = wfe_pkg::zacc_t'(1) << (ZW - 1);

	logic signed [CW-1:0] x_s [N+1];
	logic signed [CW-1:0] y_s [N+1];
	wfe_pkg::zacc_t       z_s [N+1];
	logic                 zero_s [N+1];
	logic                 vld_s [N+1];
	wfe_pkg::zacc_t       rnd;
	logic [AB-1:0]        angle_s;
	logic                 vld_out_s;

	// fold the left half plane by a half turn
	always_ff @(posedge clk) begin
		if (ce) begin
			zero_s[0] <= (x_in == '0) && (y_in == '0);
			if (x_in < 0) begin
				x_s[0] <= -CW'(x_in);
				y_s[0] <= -CW'(y_in);
				z_s[0] <= HALF_TURN;
			end else begin
				x_s[0] <= CW'(x_in);
				y_s[0] <= CW'(y_in);
				z_s[0] <= '0;
			end
		end
	end

	for (genvar i = 0; i < N; i++) begin : g_step
		logic signed [CW-1:0] dx, dy;
		assign dx = x_s[i] >>> i;
		assign dy = y_s[i] >>> i;

		always_ff @(posedge clk) begin
			if (ce) begin
				zero_s[i+1] <= zero_s[i];
				if (!y_s[i][CW-1]) begin
					x_s[i+1] <= x_s[i] + dy;
					y_s[i+1] <= y_s[i] - dx;
					z_s[i+1] <= z_s[i] + wfe_pkg::ATAN_TAB[i];
				end else begin
					x_s[i+1] <= x_s[i] - dy;
					y_s[i+1] <= y_s[i] + dx;
					z_s[i+1] <= z_s[i] - wfe_pkg::ATAN_TAB[i];
				end
			end
		end
	end

	assign rnd = z_s[N] + RND;

	always_ff @(posedge clk) begin
		if (ce) begin
			angle_s <= zero_s[N] ? '0 : rnd[ZW-1 -: AB];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k <= N; k++) begin
				vld_s[k] <= 1'b0;
			end
			vld_out_s <= 1'b0;
		end else if (ce) begin
			vld_s[0] <= in_valid;
			for (int k = 1; k <= N; k++) begin
				vld_s[k] <= vld_s[k-1];
			end
			vld_out_s <= vld_s[N];
		end
	end

	assign angle     = angle_s;
	assign out_valid = vld_out_s;

endmodule

// ===== sv/water_frame_euler_angles_unit.sv =====
// ----------------------------------------------------------------------------
// water_frame_euler_angles_unit: z-x-z Euler angles of a water molecule frame
// Builds the frame from O, H1, H2 and reports alpha, beta, gamma as binary
// angles, with a flag for a zero-length or collinear geometry.
// ----------------------------------------------------------------------------
//  port group | direction | payload
//  -----------+-----------+---------------------------------------------------
//  s_*        | in        | s_tdata: nine 24-bit coordinates O, H1, H2 (x,y,z)
//  m_*        | out       | m_tdata: alpha, beta, gamma; m_tuser: degenerate
//
//  One transfer accepted per cycle unless the output stalls; data passes the two
//  30-stage square root pipelines and the 26-stage CORDIC units.
//  Reset clears the valid bits only; no clearing pass is needed.
//  A result held on m_* with m_tready low freezes the whole pipeline and
//  s_tready drops; bubbles inside the pipeline never block it.
// ----------------------------------------------------------------------------
module water_frame_euler_angles_unit #(
	parameter int ANGLE_BITS = 16
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     s_tvalid,
	output logic                     s_tready,
	// oxygen_x, oxygen_y, oxygen_z, h1_x, h1_y, h1_z, h2_x, h2_y, h2_z
	input  logic [wfe_pkg::IN_W-1:0] s_tdata,
	output logic                     m_tvalid,
	input  logic                     m_tready,
	// alpha_angle, beta_angle, gamma_angle, zero fill
	output logic [((3*ANGLE_BITS-1+7)/8)*8-1:0] m_tdata,
	// degenerate
	output logic                     m_tuser
);

	localparam int AB     = ANGLE_BITS;
	localparam int OUT_W  = ((3 * AB - 1 + 7) / 8) * 8;
	localparam int RW     = wfe_pkg::ROOT_W;
	localparam int NW     = wfe_pkg::RAD_W;
	localparam int SQW    = wfe_pkg::SQ_W;
	localparam int PW     = wfe_pkg::PRE_W;
	localparam int GW     = wfe_pkg::GAM_W;
	localparam int IW     = wfe_pkg::CORDIC_IW;
	localparam int LIM    = wfe_pkg::PRE_LIMIT;
	localparam int FW     = $bits(wfe_pkg::wfe_frame_t);
	localparam int CZ2_DLY   = RW + 2;
	localparam int FRAME_DLY = 2 * RW + 4;
	localparam int GAM_DLY   = 5;
	localparam int R_DLY     = RW + 7;
	localparam int CORD_LAT  = wfe_pkg::CORDIC_STEPS + 2;

	logic ce;
	wfe_pkg::wfe_frame_t fr, frd, frg;
	logic fr_vld;

	// squares of the prescaled cross product
	logic signed [2*PW-1:0] sqx_c, sqy_c, sqz_c;
	logic [SQW-1:0] sqx_s1, sqy_s1, sqz_s1, cz2_d;
	logic [NW-1:0]  n1_s2, r2_s3, n2_s4;
	logic [2*RW-1:0] r2_c;
	logic [RW-1:0]  r_root, m_root, r_d;
	logic           r_vld, m_vld;
	logic           vld_s1, vld_s2, vld_s3, vld_s4;

	// gamma operands
	logic signed [GW-1:0] gy_c, p1_c, p2_c;
	logic signed [GW-1:0] gy_s5, p1_s5, p2_s5, gy_s6, gx_s6, ngy, ngx;
	logic [GW-2:0]        gym_s7, gxm_s7, gym_s8, gxm_s8, gysh, gxsh;
	logic                 gys_s7, gxs_s7, gys_s8, gxs_s8;
	logic [wfe_pkg::SHIFT_W-1:0] gsh_s8;
	logic signed [PW-1:0] gyv, gxv, gy_s9, gx_s9;
	logic                 vld_s5, vld_s6, vld_s7, vld_s8, vld_s9;

	logic [AB-1:0] alpha_c, beta_c, gamma_c;
	logic [AB-2:0] beta_sat;
	logic          al_vld, be_vld, ga_vld, degen_d;
	logic signed [PW-1:0] ncy;

	logic [OUT_W-1:0] tdata_q;
	logic             tuser_q, tvalid_q;

	// the pipeline advances unless a held result is waiting
	assign ce       = !tvalid_q || m_tready;
	assign s_tready = ce;

	wfe_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.ce        (ce),
		.in_valid  (s_tvalid),
		.in_data   (s_tdata),
		.out_valid (fr_vld),
		.out_frame (fr)
	);

	assign sqx_c = fr.cx * fr.cx;
	assign sqy_c = fr.cy * fr.cy;
	assign sqz_c = fr.cz * fr.cz;
	assign r2_c  = r_root * r_root;

	always_ff @(posedge clk) begin
		if (ce) begin
			sqx_s1 <= sqx_c[SQW-1:0];
			sqy_s1 <= sqy_c[SQW-1:0];
			sqz_s1 <= sqz_c[SQW-1:0];
			n1_s2  <= NW'(sqx_s1) + NW'(sqy_s1);
			r2_s3  <= r2_c;
			n2_s4  <= r2_s3 + NW'(cz2_d);
		end
	end

	// r = |(cx, cy)|
	wfe_isqrt #(.RW(RW)) u_sqrt_xy (
		.clk       (clk),
		.arst_n    (arst_n),
		.ce        (ce),
		.in_valid  (vld_s2),
		.radicand  (n1_s2),
		.out_valid (r_vld),
		.root      (r_root)
	);

	// hold cz^2 until r^2 is ready
	wfe_delay #(.W(SQW), .D(CZ2_DLY)) u_dly_cz2 (
		.clk  (clk),
		.ce   (ce),
		.din  (sqz_s1),
		.dout (cz2_d)
	);

	// m = |c|
	wfe_isqrt #(.RW(RW)) u_sqrt_all (
		.clk       (clk),
		.arst_n    (arst_n),
		.ce        (ce),
		.in_valid  (vld_s4),
		.radicand  (n2_s4),
		.out_valid (m_vld),
		.root      (m_root)
	);

	wfe_delay #(.W(FW), .D(FRAME_DLY)) u_dly_frame (
		.clk  (clk),
		.ce   (ce),
		.din  (fr),
		.dout (frd)
	);

	// gamma: y = d1z * |c|, x = d1y*cx - d1x*cy
	assign gy_c = frd.az * $signed({1'b0, m_root});
	assign p1_c = GW'(frd.ay * frd.cx);
	assign p2_c = GW'(frd.ax * frd.cy);
	assign ngy  = -gy_s6;
	assign ngx  = -gx_s6;
	assign gysh = gym_s8 >> gsh_s8;
	assign gxsh = gxm_s8 >> gsh_s8;
	assign gyv  = {1'b0, gysh[LIM-1:0]};
	assign gxv  = {1'b0, gxsh[LIM-1:0]};

	always_ff @(posedge clk) begin
		if (ce) begin
			gy_s5  <= gy_c;
			p1_s5  <= p1_c;
			p2_s5  <= p2_c;
			gy_s6  <= gy_s5;
			gx_s6  <= p1_s5 - p2_s5;
			gym_s7 <= gy_s6[GW-1] ? ngy[GW-2:0] : gy_s6[GW-2:0];
			gxm_s7 <= gx_s6[GW-1] ? ngx[GW-2:0] : gx_s6[GW-2:0];
			gys_s7 <= gy_s6[GW-1];
			gxs_s7 <= gx_s6[GW-1];
			gym_s8 <= gym_s7;
			gxm_s8 <= gxm_s7;
			gys_s8 <= gys_s7;
			gxs_s8 <= gxs_s7;
			gsh_s8 <= wfe_pkg::fit_shift(wfe_pkg::LEAD_W'(gym_s7 | gxm_s7));
			gy_s9  <= gys_s8 ? -gyv : gyv;
			gx_s9  <= gxs_s8 ? -gxv : gxv;
		end
	end

	// line up the alpha and beta operands with the gamma operands
	wfe_delay #(.W(FW), .D(GAM_DLY)) u_dly_frame2 (
		.clk  (clk),
		.ce   (ce),
		.din  (frd),
		.dout (frg)
	);

	wfe_delay #(.W(RW), .D(R_DLY)) u_dly_r (
		.clk  (clk),
		.ce   (ce),
		.din  (r_root),
		.dout (r_d)
	);

	assign ncy = -frg.cy;

	wfe_cordic #(.IW(IW), .AB(AB)) u_cordic_alpha (
		.clk       (clk),
		.arst_n    (arst_n),
		.ce        (ce),
		.in_valid  (vld_s9),
		.y_in      (IW'(frg.cx)),
		.x_in      (IW'(ncy)),
		.out_valid (al_vld),
		.angle     (alpha_c)
	);

	wfe_cordic #(.IW(IW), .AB(AB)) u_cordic_beta (
		.clk       (clk),
		.arst_n    (arst_n),
		.ce        (ce),
		.in_valid  (vld_s9),
		.y_in      ($signed({1'b0, r_d})),
		.x_in      (IW'(frg.cz)),
		.out_valid (be_vld),
		.angle     (beta_c)
	);

	wfe_cordic #(.IW(IW), .AB(AB)) u_cordic_gamma (
		.clk       (clk),
		.arst_n    (arst_n),
		.ce        (ce),
		.in_valid  (vld_s9),
		.y_in      (IW'(gy_s9)),
		.x_in      (IW'(gx_s9)),
		.out_valid (ga_vld),
		.angle     (gamma_c)
	);

	wfe_delay #(.W(1), .D(CORD_LAT)) u_dly_degen (
		.clk  (clk),
		.ce   (ce),
		.din  (frg.degen),
		.dout (degen_d)
	);

	// beta past pi saturates; slightly negative beta drops to zero
	always_comb begin
		if (beta_c[AB-1]) begin
			beta_sat = beta_c[AB-2] ? '0 : '1;
		end else begin
			beta_sat = beta_c[AB-2:0];
		end
	end

	always_ff @(posedge clk) begin
		if (ce) begin
			tdata_q <= OUT_W'({gamma_c, beta_sat, alpha_c});
			tuser_q <= degen_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1   <= 1'b0;
			vld_s2   <= 1'b0;
			vld_s3   <= 1'b0;
			vld_s4   <= 1'b0;
			vld_s5   <= 1'b0;
			vld_s6   <= 1'b0;
			vld_s7   <= 1'b0;
			vld_s8   <= 1'b0;
			vld_s9   <= 1'b0;
			tvalid_q <= 1'b0;
		end else if (ce) begin
			vld_s1   <= fr_vld;
			vld_s2   <= vld_s1;
			vld_s3   <= r_vld;
			vld_s4   <= vld_s3;
			vld_s5   <= m_vld;
			vld_s6   <= vld_s5;
			vld_s7   <= vld_s6;
			vld_s8   <= vld_s7;
			vld_s9   <= vld_s8;
			tvalid_q <= al_vld && be_vld && ga_vld;
		end
	end

	assign m_tvalid = tvalid_q;
	assign m_tdata  = tdata_q;
	assign m_tuser  = tuser_q;

endmodule

// ===== sv/wfe_checker.sv =====
// ----------------------------------------------------------------------------
// wfe_checker: port-level checks of the water frame Euler angle unit
// Watches the stream ports over time; attached to the top level by bind.
// ----------------------------------------------------------------------------
module wfe_checker #(
	parameter int ANGLE_BITS = 16
) (
	input logic                                    clk,
	input logic                                    arst_n,
	input logic                                    s_tvalid,
	input logic                                    s_tready,
	input logic                                    m_tvalid,
	input logic                                    m_tready,
	input logic [((3*ANGLE_BITS-1+7)/8)*8-1:0]     m_tdata,
	input logic                                    m_tuser
);

	// a stalled result holds its payload
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("result changed while stalled");

	// a degenerate molecule reports all angles as zero
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |-> m_tdata == '0)
		else $error("degenerate result with nonzero angles");

	// input side stalls exactly when a result is held back
	assert property (@(posedge clk) disable iff (!arst_n)
		s_tready == (!m_tvalid || m_tready))
		else $error("input ready does not follow output stall");

	// no result is valid when reset is released
	assert property (@(posedge clk)
		$rose(arst_n) |-> !m_tvalid)
		else $error("result valid right after reset");

	// an input transfer while stalled cannot happen
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |-> !(s_tvalid && s_tready))
		else $error("input transfer taken during output stall");

endmodule

bind water_frame_euler_angles_unit wfe_checker #(.ANGLE_BITS(ANGLE_BITS)) u_wfe_checker (.*);
